// File: rtl/core/lzwe_pkg.sv
package lzwe_pkg;

    localparam int DICT_DEPTH  = 4096;
    localparam int CODE_WIDTH  = 12;
    localparam int BYTE_W      = 8;
    localparam int FIRST_FREE  = 256;

    // Highest number of codes in use: the smaller of the store and the code space.
    localparam int CODE_LIMIT  = (DICT_DEPTH < (1 << CODE_WIDTH)) ? DICT_DEPTH
                                                                 : (1 << CODE_WIDTH);
    localparam int LIMIT_BITS  = $clog2(CODE_LIMIT);
    localparam int FREE_W      = LIMIT_BITS + 1;
    // Hash table at twice the entry count keeps probe chains short.
    localparam int HASH_BITS   = LIMIT_BITS + 1;
    localparam int KEY_W       = CODE_WIDTH + BYTE_W;
    localparam int OUT_TDATA_W = ((CODE_WIDTH + 7) / 8) * 8;

    localparam int IQ_DEPTH    = 4;
    localparam int IQ_AW       = $clog2(IQ_DEPTH);
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_AW       = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic                  last;
        logic [CODE_WIDTH-1:0] code;
    } code_beat_t;

    typedef struct packed {
        logic [HASH_BITS-1:0] slot;
        logic [KEY_W-1:0]     key;
    } entry_t;

    function automatic logic [HASH_BITS-1:0] pair_hash(input logic [CODE_WIDTH-1:0] pfx,
                                                        input logic [BYTE_W-1:0] b);
        logic [HASH_BITS-1:0] hp;
        logic [HASH_BITS-1:0] hb;
        hp = HASH_BITS'(pfx);
        hb = HASH_BITS'(b) << (HASH_BITS - BYTE_W);
        return hp ^ hb ^ HASH_BITS'(b);
    endfunction

endpackage

// File: rtl/core/lzwe_front.sv
module lzwe_front
    import lzwe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              item_valid,
    input  logic              item_pop,
    output item_t             item
);

    item_t              q_mem [IQ_DEPTH];
    logic [IQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IQ_AW:0]     count_reg, count_next;
    logic               start_reg, start_next;
    logic               push;
    logic               pop;

    assign s_tready   = (count_reg != (IQ_AW+1)'(IQ_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (IQ_AW+1)'(push) - (IQ_AW+1)'(pop);
        // The beat after a last beat opens a new stream.
        start_next  = push ? s_tlast : start_reg;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{first: start_reg, last: s_tlast, data: s_tdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            start_reg  <= 1'b1;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            start_reg  <= start_next;
        end
    end

endmodule

// File: rtl/core/lzwe_out_queue.sv
module lzwe_out_queue
    import lzwe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  code_beat_t             push_beat,
    output logic                   room2,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    code_beat_t         q_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_AW:0]     count_reg, count_next;
    logic               pop;
    code_beat_t         head;

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = OUT_TDATA_W'(head.code);
    assign m_tlast  = head.last;
    assign pop      = m_tvalid && m_tready;
    assign room2    = (count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (OQ_AW+1)'(push) - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/lzwe_engine.sv
module lzwe_engine
    import lzwe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_valid,
    output logic       item_pop,
    input  item_t      item,
    input  logic       room2,
    output logic       push,
    output code_beat_t push_beat
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SLOT  = 4'b0010,
        S_ENTRY = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CODE_WIDTH-1:0] prefix_reg, prefix_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [HASH_BITS-1:0]  probe_reg, probe_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [CODE_WIDTH-1:0] cand_reg, cand_next;

    // Hash slots hold a code; entries hold the pair and the slot that owns it.
    logic [CODE_WIDTH-1:0] slot_mem  [1 << HASH_BITS];
    entry_t                entry_mem [CODE_LIMIT];
    logic [CODE_WIDTH-1:0] slot_rd_reg;
    entry_t                entry_rd_reg;
    logic [HASH_BITS-1:0]  slot_raddr;
    logic [LIMIT_BITS-1:0] entry_raddr;
    logic                  ins_we;

    logic [KEY_W-1:0]      cur_key;
    logic                  cand_live;
    logic                  room_left;

    assign cur_key   = {prefix_reg, byte_reg};
    assign cand_live = ({1'b0, slot_rd_reg} >= (CODE_WIDTH+1)'(FIRST_FREE)) &&
                       ({1'b0, slot_rd_reg} <  (CODE_WIDTH+1)'(free_reg));
    assign room_left = (free_reg < FREE_W'(CODE_LIMIT));

    always_ff @(posedge aclk) begin
        if (ins_we) begin
            slot_mem[probe_reg] <= CODE_WIDTH'(free_reg);
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ins_we) begin
            entry_mem[free_reg[LIMIT_BITS-1:0]] <= '{slot: probe_reg, key: cur_key};
        end
        entry_rd_reg <= entry_mem[entry_raddr];
    end

    always_comb begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        probe_next  = probe_reg;
        free_next   = free_reg;
        cand_next   = cand_reg;
        slot_raddr  = probe_reg;
        entry_raddr = slot_rd_reg[LIMIT_BITS-1:0];
        ins_we      = 1'b0;
        item_pop    = 1'b0;
        push        = 1'b0;
        push_beat   = '{last: 1'b0, code: prefix_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (item_valid && room2) begin
                    item_pop  = 1'b1;
                    byte_next = item.data;
                    last_next = item.last;
                    if (item.first) begin
                        prefix_next = CODE_WIDTH'(item.data);
                        if (item.last) begin
                            push      = 1'b1;
                            push_beat = '{last: 1'b1, code: CODE_WIDTH'(item.data)};
                        end
                    end else begin
                        probe_next = pair_hash(prefix_reg, item.data);
                        slot_raddr = pair_hash(prefix_reg, item.data);
                        state_next = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                if (cand_live) begin
                    cand_next  = slot_rd_reg;
                    state_next = S_ENTRY;
                end else begin
                    push        = 1'b1;
                    ins_we      = room_left;
                    free_next   = room_left ? free_reg + 1'b1 : free_reg;
                    prefix_next = CODE_WIDTH'(byte_reg);
                    state_next  = last_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_ENTRY: begin
                if (entry_rd_reg.slot != probe_reg) begin
                    // Stale slot contents: the slot is free.
                    push        = 1'b1;
                    ins_we      = room_left;
                    free_next   = room_left ? free_reg + 1'b1 : free_reg;
                    prefix_next = CODE_WIDTH'(byte_reg);
                    state_next  = last_reg ? S_FLUSH : S_IDLE;
                end else if (entry_rd_reg.key == cur_key) begin
                    prefix_next = cand_reg;
                    state_next  = last_reg ? S_FLUSH : S_IDLE;
                end else begin
                    probe_next = probe_reg + 1'b1;
                    slot_raddr = probe_reg + 1'b1;
                    state_next = S_SLOT;
                end
            end
            S_FLUSH: begin
                push       = 1'b1;
                push_beat  = '{last: 1'b1, code: prefix_reg};
                free_next  = FREE_W'(FIRST_FREE);
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prefix_reg <= prefix_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        probe_reg  <= probe_next;
        cand_reg   <= cand_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            free_reg  <= FREE_W'(FIRST_FREE);
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
        end
    end

endmodule

// File: rtl/core/lzw_byte_encoder.sv
// Path: a beat is registered in the front queue before the engine sees it, a code in the
//   output queue before it shows. The engine takes a stream's first byte in S_IDLE; any
//   other reads its hash slot in S_SLOT and each occupied slot's entry in S_ENTRY, and a last
//   byte not also first emits its code in S_FLUSH. Pacing: a byte is taken only once the
//   last is done, set by the slot-memory read and, on an occupied slot, the entry read.
// Reset: aresetn is synchronous and active low; it empties both queues and opens a new stream.
module lzw_byte_encoder
    import lzwe_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // bits 7:0 in_byte
    input  logic                   s_tlast,   // in_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // bits 11:0 out_code, rest zero
    output logic                   m_tlast    // out_last
);

    // The front queues input beats and marks the first beat of each stream.
    item_t      item;
    logic       item_valid;
    logic       item_pop;
    // The engine searches the hashed dictionary and hands codes to the output queue.
    logic       room2;
    logic       push;
    code_beat_t push_beat;

    lzwe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    lzwe_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .room2      (room2),
        .push       (push),
        .push_beat  (push_beat)
    );

    // The engine only takes a beat when two output slots are free, so a miss
    // on the last beat can always deliver both codes.
    lzwe_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .room2     (room2),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/core/lzwe_checker.sv
module lzwe_checker
    import lzwe_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    a_reset_out_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_reset_in_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >> CODE_WIDTH) == '0))
        else $error("code exceeds code width");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output beat changed");

endmodule

bind lzw_byte_encoder lzwe_checker u_lzwe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: bench/lzw_byte_encoder_tb.sv
`timescale 1ns / 100ps

module lzw_byte_encoder_tb;
    import lzwe_pkg::*;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } byte_beat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    lzw_byte_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Bytes waiting to be offered, and the codes the encoder should emit.
    byte_beat_t pending_bytes[$];
    code_beat_t expected_codes[$];

    // Own copy of the encoder state: the dictionary is held as a map from
    // the (prefix, byte) key to its code.
    int unsigned      pair_code[int unsigned];
    int unsigned      next_code = FIRST_FREE;
    logic [CODE_WIDTH-1:0] cur_prefix = '0;
    bit               have_prefix = 1'b0;

    int  bytes_sent = 0;
    int  total_bytes = 0;
    int  mismatches = 0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    function automatic code_beat_t make_code(logic [CODE_WIDTH-1:0] c, logic l);
        code_beat_t r;
        r.code = c;
        r.last = l;
        return r;
    endfunction

    // Work out the codes one accepted byte gives rise to.
    task automatic encode_byte(input byte_beat_t bt);
        int unsigned key;
        key = 32'({cur_prefix, bt.data});
        if (!have_prefix) begin
            cur_prefix = CODE_WIDTH'(bt.data);
            have_prefix = 1'b1;
        end else if (pair_code.exists(key)) begin
            cur_prefix = CODE_WIDTH'(pair_code[key]);
        end else begin
            expected_codes.insert(expected_codes.size(), make_code(cur_prefix, 1'b0));
            if (next_code < CODE_LIMIT) begin
                pair_code[key] = next_code;
                next_code++;
            end
            cur_prefix = CODE_WIDTH'(bt.data);
        end
        if (bt.last) begin
            expected_codes.insert(expected_codes.size(), make_code(cur_prefix, 1'b1));
            pair_code.delete();
            next_code = FIRST_FREE;
            cur_prefix = '0;
            have_prefix = 1'b0;
        end
    endtask

    // Idling plan: the receiver is lazy in the first third, the sender in
    // the second, and neither idles in the last.
    function automatic bit sender_idles();
        if (bytes_sent < total_bytes / 3)
            return $urandom_range(99) < 34;
        if (bytes_sent < 2 * total_bytes / 3)
            return $urandom_range(99) < 82;
        return 1'b0;
    endfunction

    function automatic bit receiver_idles();
        if (bytes_sent < total_bytes / 3)
            return $urandom_range(99) < 82;
        if (bytes_sent < 2 * total_bytes / 3)
            return $urandom_range(99) < 34;
        return 1'b0;
    endfunction

    // Driver: a beat is held until accepted, then the next one is offered
    // unless the sender chooses to idle.
    always @(posedge aclk) begin
        byte_beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                encode_byte({s_tlast, s_tdata});
                bytes_sent++;
            end
            if (pending_bytes.size() > 0 && !sender_idles()) begin
                nb = pending_bytes.pop_front();
                s_tdata  <= nb.data;
                s_tlast  <= nb.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off so that the encoder backs up
    // and stalls its input while bytes keep being offered.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && bytes_sent > total_bytes / 2) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !receiver_idles();
        end
    end

    // Monitor: every code beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        code_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected code beat: code %0d last %0b",
                             m_tdata[CODE_WIDTH-1:0], m_tlast);
            end else begin
                want = expected_codes.pop_front();
                if (m_tdata != OUT_TDATA_W'(want.code) || m_tlast != want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("code mismatch: expected code %0d last %0b, got tdata %0d last %0b",
                                 want.code, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic add_byte(input logic [BYTE_W-1:0] d, input logic l);
        byte_beat_t bt;
        bt.data = d;
        bt.last = l;
        pending_bytes.insert(pending_bytes.size(), bt);
    endtask

    // A stream of random bytes drawn from a small alphabet, so that the
    // dictionary gets hits and prefixes grow, or from all 256 values.
    task automatic add_stream(input int len, input int alphabet);
        int base;
        base = $urandom_range(255);
        for (int i = 0; i < len; i++)
            add_byte(BYTE_W'(base + $urandom_range(alphabet - 1)), i == len - 1);
    endtask

    initial begin
        // Directed part: a one-byte stream, both extreme byte values,
        // repeats that grow the prefix, a short two-byte stream and an alternating one.
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        for (int i = 0; i < 10; i++)
            add_byte((i % 2) ? 8'hAA : 8'h55, i == 9);

        // A long stream over the whole byte range grows a sizeable dictionary.
        add_stream(600, 256);

        // Random streams, mostly short with a narrow alphabet.
        while (pending_bytes.size() < 1000) begin
            if ($urandom_range(9) < 7)
                add_stream($urandom_range(1, 40), $urandom_range(1, 4));
            else
                add_stream($urandom_range(1, 60), 256);
        end
        total_bytes = pending_bytes.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() > 0 || s_tvalid || expected_codes.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (mismatches == 0 && expected_codes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
